// File: hdl/assert_macros.svh
// Assertion macros used by the checker of the cost engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition in one cycle forces another in the next cycle.
`define FMESAD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fmesad: next-cycle check failed");

// Check that a condition forces another in the same cycle.
`define FMESAD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fmesad: same-cycle check failed");

`endif

// File: hdl/fmesad_pkg.sv
// Package of the fractional motion estimation cost engine: types and constants.
package fmesad_pkg;

   // Field widths of the request and response
   localparam int CMD_BITS       = 2;
   localparam int CAND_BITS      = 6;
   localparam int COST_BITS      = 16;
   localparam int PIXEL_BITS     = 8;
   localparam int SAD_BITS       = 17;

   // Default number of candidate positions
   localparam int NUM_CANDIDATES_DEF = 48;

   // Request command codes
   localparam logic [CMD_BITS-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_ACCUM  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_SELECT = 2'd2;

   typedef struct packed {
      logic [CMD_BITS-1:0]   command;
      logic [CAND_BITS-1:0]  candidate;
      logic [COST_BITS-1:0]  cost;
      logic [PIXEL_BITS-1:0] orig_pixel;
      logic [PIXEL_BITS-1:0] cand_pixel;
   } fmesad_req_type;

   typedef struct packed {
      logic [SAD_BITS-1:0]  min_sad;
      logic [CAND_BITS-1:0] best_candidate;
   } fmesad_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_SCAN,
      ST_EMIT
   } fmesad_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic take_load;
      logic take_accum;
      logic take_select;
      logic acc_write;
      logic scan_step;
   } fmesad_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic scan_last;
   } fmesad_stat_type;

endpackage

// File: hdl/fmesad_ctrl.sv
// Controller state machine of the cost engine: request decode and sequencing.
module fmesad_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [fmesad_pkg::CMD_BITS-1:0] command,
   input  fmesad_pkg::fmesad_stat_type stat,
   output logic                        busy,
   output logic                        rsp_valid,
   output fmesad_pkg::fmesad_cmd_type  cmd
);
   import fmesad_pkg::*;

   fmesad_state_type state_ff;
   fmesad_state_type state_in;
   logic             take;

   assign take = start && (state_ff == ST_IDLE);

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance the state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (command)
                  CMD_ACCUM:  state_in = ST_ACC;
                  CMD_SELECT: state_in = ST_SCAN;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_ACC: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (stat.scan_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Drive datapath commands and handshake outputs
   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy            = 1'b0;
            cmd.take_load   = take && (command == CMD_LOAD);
            cmd.take_accum  = take && (command == CMD_ACCUM);
            cmd.take_select = take && (command == CMD_SELECT);
         end
         ST_ACC: begin
            cmd.acc_write = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// File: hdl/fmesad_dp.sv
// Datapath of the cost engine: accumulator store, update adder and minimum scan.
module fmesad_dp #(
   parameter int NUM_CANDIDATES = fmesad_pkg::NUM_CANDIDATES_DEF
) (
   input  logic                        clock,
   input  fmesad_pkg::fmesad_req_type  req_data,
   input  fmesad_pkg::fmesad_cmd_type  cmd,
   output fmesad_pkg::fmesad_stat_type stat,
   output fmesad_pkg::fmesad_rsp_type  rsp_data
);
   import fmesad_pkg::*;

   localparam int ADDR_W = (NUM_CANDIDATES > 1) ? $clog2(NUM_CANDIDATES) : 1;
   localparam int CMP_W  = CAND_BITS + 1;
   localparam int SUM_W  = SAD_BITS + 1;

   logic [SAD_BITS-1:0]   mem [NUM_CANDIDATES];
   logic [SAD_BITS-1:0]   rd_data_ff;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [SAD_BITS-1:0]   wr_data;

   logic [ADDR_W-1:0]     req_addr;
   logic                  cand_ok;
   logic [PIXEL_BITS-1:0] diff;
   logic [PIXEL_BITS-1:0] diff_ff;
   logic [ADDR_W-1:0]     acc_addr_ff;
   logic                  acc_ok_ff;
   logic [SUM_W-1:0]      sum;
   logic [SAD_BITS-1:0]   sum_sat;

   logic [ADDR_W-1:0]     cnt_ff;
   logic                  last;
   logic [SAD_BITS-1:0]   best_ff;
   logic [ADDR_W-1:0]     best_idx_ff;

   assign req_addr = req_data.candidate[ADDR_W-1:0];
   assign cand_ok  = {1'b0, req_data.candidate} < CMP_W'(NUM_CANDIDATES);

   // Absolute pixel difference
   assign diff = (req_data.orig_pixel >= req_data.cand_pixel) ?
                 (req_data.orig_pixel - req_data.cand_pixel) :
                 (req_data.cand_pixel - req_data.orig_pixel);

   // Add the difference to the stored value, clip at all ones
   assign sum     = {1'b0, rd_data_ff} + SUM_W'(diff_ff);
   assign sum_sat = sum[SAD_BITS] ? {SAD_BITS{1'b1}} : sum[SAD_BITS-1:0];

   // Select store write port
   always_comb begin
      if (cmd.take_load) begin
         wr_en   = cand_ok;
         wr_addr = req_addr;
         wr_data = SAD_BITS'(req_data.cost);
      end else begin
         wr_en   = cmd.acc_write && acc_ok_ff;
         wr_addr = acc_addr_ff;
         wr_data = sum_sat;
      end
   end

   // Select store read address
   assign last = (cnt_ff == ADDR_W'(NUM_CANDIDATES - 1));
   always_comb begin
      if (cmd.take_select) begin
         rd_addr = '0;
      end else if (cmd.scan_step) begin
         rd_addr = last ? cnt_ff : cnt_ff + ADDR_W'(1);
      end else begin
         rd_addr = cand_ok ? req_addr : '0;
      end
   end

   // Store with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Capture the accumulate request
   always_ff @(posedge clock) begin
      if (cmd.take_accum) begin
         diff_ff     <= diff;
         acc_addr_ff <= req_addr;
         acc_ok_ff   <= cand_ok;
      end
   end

   // Walk the store and keep the running minimum, first index on a tie
   always_ff @(posedge clock) begin
      if (cmd.take_select) begin
         cnt_ff <= '0;
      end else if (cmd.scan_step) begin
         cnt_ff <= cnt_ff + ADDR_W'(1);
         if ((cnt_ff == '0) || (rd_data_ff < best_ff)) begin
            best_ff     <= rd_data_ff;
            best_idx_ff <= cnt_ff;
         end
      end
   end

   assign stat.scan_last          = last;
   assign rsp_data.min_sad        = best_ff;
   assign rsp_data.best_candidate = CAND_BITS'(best_idx_ff);

endmodule

// File: hdl/fractional_me_sad_best_select.sv
// Top level of the fractional motion estimation cost engine.
// Keeps one cost accumulator per sub-pixel candidate. A load request writes a
// rate cost into a candidate's accumulator while busy stays low. An
// accumulate request adds |orig_pixel - cand_pixel|: the accumulator store is
// read in the cycle of acceptance and written back in the next. During a
// select request the scan reads one store entry per cycle, and then the result
// is strobed on rsp_valid for one cycle, after which busy drops. The receiver
// must take the result in that cycle. A select issued while some candidate has
// no cost loaded reports an undefined value for that candidate.
module fractional_me_sad_best_select #(
   parameter int NUM_CANDIDATES = fmesad_pkg::NUM_CANDIDATES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  fmesad_pkg::fmesad_req_type req_data,
   output logic                       rsp_valid,
   output fmesad_pkg::fmesad_rsp_type rsp_data
);
   import fmesad_pkg::*;

   fmesad_cmd_type  cmd;
   fmesad_stat_type stat;

   // Sequence the requests
   fmesad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .command   (req_data.command),
      .stat      (stat),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Store, accumulate and scan
   fmesad_dp #(
      .NUM_CANDIDATES (NUM_CANDIDATES)
   ) u_dp (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// File: hdl/fmesad_checker.sv
// Port-level checker of the cost engine and its bind to the top level.
`include "assert_macros.svh"

module fmesad_checker #(
   parameter int NUM_CANDIDATES = fmesad_pkg::NUM_CANDIDATES_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input fmesad_pkg::fmesad_req_type req_data,
   input logic                       rsp_valid,
   input fmesad_pkg::fmesad_rsp_type rsp_data
);
   import fmesad_pkg::*;

   localparam int CMP_W = CAND_BITS + 1;

   logic take;
   logic take_select;
   logic take_load;
   logic idx_ok;

   assign take        = start && !busy;
   assign take_select = take && (req_data.command == CMD_SELECT);
   assign take_load   = take && (req_data.command == CMD_LOAD);
   assign idx_ok      = {1'b0, rsp_data.best_candidate} < CMP_W'(NUM_CANDIDATES);

   // A select keeps the block busy through the scan
   `FMESAD_ASSERT_NEXT(a_select_busy, clock, reset, take_select, busy && !rsp_valid)
   // A load leaves the block ready
   `FMESAD_ASSERT_NEXT(a_load_ready, clock, reset, take_load, !busy)
   // The result strobe lasts one cycle and releases the block
   `FMESAD_ASSERT_NEXT(a_rsp_release, clock, reset, rsp_valid, !rsp_valid && !busy)
   // A result never appears while a request can be taken
   `FMESAD_ASSERT_SAME(a_rsp_busy, clock, reset, rsp_valid, busy)
   // The reported index names a real candidate
   `FMESAD_ASSERT_SAME(a_rsp_index, clock, reset, rsp_valid, idx_ok)

endmodule

bind fractional_me_sad_best_select fmesad_checker #(
   .NUM_CANDIDATES (NUM_CANDIDATES)
) u_fmesad_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
